// ----- rtl/core/stqr_pkg.sv -----
// ----------------------------------------------------------------------------
// stqr_pkg
// Shared types and constants for the sorted table range query block.
// ----------------------------------------------------------------------------
package stqr_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned SIZE_W      = 31;

  // Input item layout in s_axis_tdata, lowest bit first
  localparam int unsigned WIDX_LSB    = 0;
  localparam int unsigned ESIZE_LSB   = WIDX_LSB + ADDR_W;
  localparam int unsigned LOWER_LSB   = ESIZE_LSB + SIZE_W;
  localparam int unsigned UPPER_LSB   = LOWER_LSB + SIZE_W;
  localparam int unsigned IN_BITS     = UPPER_LSB + SIZE_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Result item layout in m_axis_tdata, lowest bit first
  localparam int unsigned FIRST_LSB   = 0;
  localparam int unsigned COUNT_LSB   = FIRST_LSB + CNT_W;
  localparam int unsigned HIT_LSB     = COUNT_LSB + CNT_W;
  localparam int unsigned OUT_BITS    = HIT_LSB + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic        REG_ENTRY_COUNT = 1'b0;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOW  = 4'b0010,
    ST_HIGH = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

endpackage

// ----- rtl/core/sorted_table_range_query_top.sv -----
// ----------------------------------------------------------------------------
// sorted_table_range_query_top
// Sorted size table with a two-pass binary search range query.
// ----------------------------------------------------------------------------
// Write item: the entry lands in the table at the accepting edge.
// Query item: two binary searches run in turn, each of at most 11 probes over 1024
//   entries. One probe per cycle, paced by the single registered read port of the table memory.
// Flow: the next item is taken only once a query has ended, and a waiting result can
//   hold it back further. Reset clears the sequencer, entry_count and result valid.
module sorted_table_range_query_top
  import stqr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: write_index[9:0], entry_size[40:10], lower_size[71:41],
  //        upper_size[102:72], zero pad[103]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: mode[0]
  input  logic [0:0]             s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: first_index[10:0], match_count[21:11], any_hit[22], zero pad[23]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic             reg_idx;
  logic             cfg_wr;
  logic [CNT_W-1:0] entry_count_q;
  logic [CNT_W-1:0] n_clamp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_wr && reg_idx == REG_ENTRY_COUNT) begin
      entry_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_ENTRY_COUNT) ?
                  {{(APB_DATA_W-CNT_W){1'b0}}, entry_count_q} : '0;

  // Searches never look past the table, whatever software programmed
  assign n_clamp = (entry_count_q > CNT_W'(TABLE_DEPTH)) ?
                   CNT_W'(TABLE_DEPTH) : entry_count_q;

  // --------------------------------------------------------------------------
  // Input item unpacking
  // --------------------------------------------------------------------------
  mode_e             in_mode;
  logic [ADDR_W-1:0] in_widx;
  logic [SIZE_W-1:0] in_esize;
  logic [SIZE_W-1:0] in_lower;
  logic [SIZE_W-1:0] in_upper;
  logic              s_accept;

  assign in_mode  = mode_e'(s_axis_tuser[0]);
  assign in_widx  = s_axis_tdata[WIDX_LSB  +: ADDR_W];
  assign in_esize = s_axis_tdata[ESIZE_LSB +: SIZE_W];
  assign in_lower = s_axis_tdata[LOWER_LSB +: SIZE_W];
  assign in_upper = s_axis_tdata[UPPER_LSB +: SIZE_W];
  assign s_accept = s_axis_tvalid & s_axis_tready;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  first_q, first_d;   // search window start
  logic [CNT_W-1:0]  len_q, len_d;       // search window length
  logic              pend_q, pend_d;     // a probe read is in flight
  logic [CNT_W-1:0]  lo_q, lo_d;         // result of the first search
  logic [SIZE_W-1:0] lower_q, upper_q;
  logic [SIZE_W-1:0] rdata_q;

  logic              m_valid_q, m_valid_d;
  logic [CNT_W-1:0]  out_first_q, out_count_q;
  logic              out_load;
  logic              out_free;

  // Only take items when no query is under way; writes go straight through
  // even while a finished result waits downstream.
  assign s_axis_tready = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // Search step: consume the probe that returned, then aim the next one
  // --------------------------------------------------------------------------
  logic              searching;
  logic [CNT_W-1:0]  half_cur;
  logic [CNT_W-1:0]  probe_cur;
  logic              go_right;
  logic [CNT_W-1:0]  first_n, len_n, half_n, probe_n;
  logic              rd_en;
  logic [ADDR_W-1:0] raddr;

  assign searching = (state_q == ST_LOW) || (state_q == ST_HIGH);
  assign half_cur  = len_q >> 1;
  assign probe_cur = first_q + half_cur;

  // First pass moves right past sizes below lower bound; second pass moves
  // right past sizes not above the upper bound.
  assign go_right = (state_q == ST_LOW) ? (rdata_q < lower_q) : !(upper_q < rdata_q);

  always_comb begin
    first_n = first_q;
    len_n   = len_q;
    if (pend_q) begin
      if (go_right) begin
        first_n = probe_cur + CNT_W'(1);
        len_n   = len_q - half_cur - CNT_W'(1);
      end else begin
        len_n   = half_cur;
      end
    end
  end

  assign half_n  = len_n >> 1;
  assign probe_n = first_n + half_n;
  assign raddr   = probe_n[ADDR_W-1:0];
  assign rd_en   = searching && (len_n != '0);

  // --------------------------------------------------------------------------
  // Table memory: one write port for write items, one registered read port
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] size_mem [TABLE_DEPTH];
  logic              wr_en;

  assign wr_en = s_accept && (in_mode == MODE_WRITE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      size_mem[in_widx] <= in_esize;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= size_mem[raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d  = state_q;
    first_d  = first_q;
    len_d    = len_q;
    pend_d   = pend_q;
    lo_d     = lo_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && in_mode == MODE_QUERY) begin
          first_d = '0;
          len_d   = n_clamp;
          pend_d  = 1'b0;
          state_d = ST_LOW;
        end
      end
      ST_LOW: begin
        first_d = first_n;
        len_d   = len_n;
        pend_d  = rd_en;
        if (len_n == '0) begin
          // Second pass starts where the first one ended
          lo_d    = first_n;
          len_d   = n_clamp - first_n;
          pend_d  = 1'b0;
          state_d = ST_HIGH;
        end
      end
      ST_HIGH: begin
        first_d = first_n;
        len_d   = len_n;
        pend_d  = rd_en;
        if (len_n == '0) begin
          pend_d  = 1'b0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold the end index until the result register frees up
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        pend_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    len_q   <= len_d;
    lo_q    <= lo_d;
    if (s_accept && in_mode == MODE_QUERY) begin
      lower_q <= in_lower;
      upper_q <= in_upper;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_first_q <= lo_q;
      out_count_q <= first_q - lo_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                          (out_count_q != '0), out_count_q, out_first_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_window_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    searching |-> ({1'b0, first_q} + {1'b0, len_q}) <= {1'b0, n_clamp})
    else $error("search window runs past the table in use");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (probe_n < n_clamp))
    else $error("probe address beyond the table in use");

  a_pend_only_searching: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> searching)
    else $error("probe read in flight outside a search");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ({1'b0, out_first_q} + {1'b0, out_count_q}) <= {1'b0, n_clamp})
    else $error("result range exceeds the table in use");

  a_no_load_over_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !out_load)
    else $error("result overwritten before it was taken");

endmodule
